FILE: sv/dsr_pkg.sv
package dsr_pkg;

    localparam int unsigned ByteW = 8;

    // Parser position, one flop per phase.
    typedef enum logic [10:0] {
        PH_SEQ_TAG = 11'b000_0000_0001,
        PH_TOT_LEN = 11'b000_0000_0010,
        PH_R_TAG   = 11'b000_0000_0100,
        PH_R_LEN   = 11'b000_0000_1000,
        PH_R_FIRST = 11'b000_0001_0000,
        PH_R_BODY  = 11'b000_0010_0000,
        PH_S_TAG   = 11'b000_0100_0000,
        PH_S_LEN   = 11'b000_1000_0000,
        PH_S_FIRST = 11'b001_0000_0000,
        PH_S_BODY  = 11'b010_0000_0000,
        PH_DONE    = 11'b100_0000_0000
    } phase_t;

    localparam logic [ByteW-1:0] LeadZero = 8'h00;

    // One raw output item.
    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             is_s;
        logic             last;
    } raw_item_t;

endpackage

FILE: sv/dsr_parser.sv
module dsr_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [dsr_pkg::ByteW-1:0]     in_byte,
    input  logic                          in_last,
    output logic                          emit,
    output dsr_pkg::raw_item_t            result
);

    dsr_pkg::phase_t               phase_reg;
    dsr_pkg::phase_t               phase_next;
    logic [dsr_pkg::ByteW-1:0]     left_reg;
    logic [dsr_pkg::ByteW-1:0]     left_next;
    logic [dsr_pkg::ByteW-1:0]     left_dec;
    logic                          in_value;
    logic                          first;
    logic                          is_s;

    assign left_dec = left_reg - 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        in_value   = 1'b0;
        first      = 1'b0;
        is_s       = 1'b0;
        unique case (phase_reg)
            dsr_pkg::PH_SEQ_TAG: phase_next = dsr_pkg::PH_TOT_LEN;
            dsr_pkg::PH_TOT_LEN: phase_next = dsr_pkg::PH_R_TAG;
            dsr_pkg::PH_R_TAG:   phase_next = dsr_pkg::PH_R_LEN;
            dsr_pkg::PH_R_LEN:
            begin
                left_next  = in_byte;
                phase_next = (in_byte == '0) ? dsr_pkg::PH_S_TAG : dsr_pkg::PH_R_FIRST;
            end
            dsr_pkg::PH_R_FIRST:
            begin
                in_value = 1'b1;
                first    = 1'b1;
            end
            dsr_pkg::PH_R_BODY:  in_value = 1'b1;
            dsr_pkg::PH_S_TAG:   phase_next = dsr_pkg::PH_S_LEN;
            dsr_pkg::PH_S_LEN:
            begin
                left_next  = in_byte;
                phase_next = (in_byte == '0) ? dsr_pkg::PH_DONE : dsr_pkg::PH_S_FIRST;
            end
            dsr_pkg::PH_S_FIRST:
            begin
                in_value = 1'b1;
                first    = 1'b1;
                is_s     = 1'b1;
            end
            dsr_pkg::PH_S_BODY:
            begin
                in_value = 1'b1;
                is_s     = 1'b1;
            end
            default:             phase_next = dsr_pkg::PH_DONE;
        endcase

        if (in_value)
        begin
            left_next = left_dec;
            if (left_dec == '0)
                phase_next = is_s ? dsr_pkg::PH_DONE : dsr_pkg::PH_S_TAG;
            else
                phase_next = is_s ? dsr_pkg::PH_S_BODY : dsr_pkg::PH_R_BODY;
        end

        if (in_last)
        begin
            phase_next = dsr_pkg::PH_SEQ_TAG;
            left_next  = '0;
        end
    end

    // A leading zero on the first value byte is dropped.
    assign emit        = in_value && !(first && in_byte == dsr_pkg::LeadZero);
    assign result.data = in_byte;
    assign result.is_s = is_s;
    assign result.last = is_s && (left_reg == 8'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dsr_pkg::PH_SEQ_TAG;
            left_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

FILE: sv/dsr_out_reg.sv
module dsr_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  dsr_pkg::raw_item_t    item,
    output logic                  free,
    output logic                  valid,
    input  logic                  ready,
    output dsr_pkg::raw_item_t    held
);

    logic               valid_reg;
    logic               valid_next;
    dsr_pkg::raw_item_t item_reg;

    // The slot can be refilled in the same cycle its item is taken.
    assign free = !valid_reg || ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (ready)
            valid_next = 1'b0;
        if (load)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item;
    end

    assign valid = valid_reg;
    assign held  = item_reg;

endmodule

FILE: sv/der_signature_to_raw_core.sv
// DER ECDSA signature to raw r and s bytes.
//
// The slave stream carries the DER encoding one byte per item, with tlast on
// the final byte of each signature. The master stream carries the value bytes
// of r and then of s, with a zero first byte of each integer dropped; tuser
// is high on bytes of s and tlast is high on the final byte of s.
// Tags and the total length are skipped without checks, and bytes after s are
// ignored until the input tlast, which returns the parser to its start.
//
// Each item passes an input register and then the parser, whose result is
// written into an output register that drives the master side. One item is
// taken every cycle while the master side keeps up, because the parser
// handles one byte per cycle.
// When the master side stalls, the output register holds its item, the input
// register fills, and s_axis_tready falls until the master side takes the
// held item.
// Reset empties both registers and puts the parser back to expect a sequence
// tag with no value bytes pending.
module der_signature_to_raw_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // in_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] out_is_s
    output logic       m_axis_tlast    // out_last
);

    logic                      in_valid_reg;
    logic                      in_valid_next;
    logic [dsr_pkg::ByteW-1:0] in_byte_reg;
    logic                      in_last_reg;
    logic                      advance;
    logic                      emit;
    logic                      out_free;
    dsr_pkg::raw_item_t        result;
    dsr_pkg::raw_item_t        held;

    // The held byte moves into the parser only when the output register can
    // take whatever it produces.
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (advance)
            in_valid_next = 1'b0;
        if (s_axis_tvalid && s_axis_tready)
            in_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    dsr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .emit    (emit),
        .result  (result)
    );

    dsr_out_reg u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (advance && emit),
        .item  (result),
        .free  (out_free),
        .valid (m_axis_tvalid),
        .ready (m_axis_tready),
        .held  (held)
    );

    assign m_axis_tdata = held.data;
    assign m_axis_tuser = held.is_s;
    assign m_axis_tlast = held.last;

endmodule
